@@ hdl/assert_macros.svh @@
// assertion macros used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is asserted
`define KRTA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the next cycle
`define KRTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `KRTA_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ hdl/krta_pkg.sv @@
// types and constants of the keyed record table allocator
`timescale 1ns / 1ps

package krta_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ALIGN_MASK  = 63;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W       = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [16:0] ALIGN_MASK_X  = 17'(ALIGN_MASK);
  localparam logic [7:0]  MAX_ITEMS_RST = 8'd126;
  localparam logic [2:0]  NUM_PART_RST  = 3'd4;
  localparam logic [15:0] CAPACITY_RST  = 16'd64756;
  localparam logic [31:0] VERSION_RST   = 32'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SPACE  = 2'd2
  } krta_status_e;

  typedef enum logic [1:0] {
    CFG_MAX_ITEMS = 2'd0,
    CFG_NUM_PART  = 2'd1,
    CFG_CAPACITY  = 2'd2
  } krta_cfg_idx_e;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } krta_mode_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] record_id;
    logic [15:0] length;
  } krta_req_t;

  typedef struct packed {
    krta_status_e status;
    logic [15:0]  byte_ofs;
    logic [15:0]  result_length;
    logic [31:0]  new_version;
    logic [1:0]   store_partition;
    logic         store_needed;
  } krta_rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] offset;
    logic [15:0] size;
  } krta_entry_t;

  localparam int ENTRY_W = $bits(krta_entry_t);

  // settings seen by the controller, capacity write loads free space at once
  typedef struct packed {
    logic [7:0]  max_items;
    logic [2:0]  num_partitions;
    logic        cap_we;
    logic [15:0] cap_value;
  } krta_cfg_t;

  typedef struct packed {
    logic                re;
    logic [IDX_W-1:0]    raddr;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    krta_entry_t         wdata;
  } krta_ram_req_t;

endpackage

@@ hdl/krta_table_ram.sv @@
// simple dual-port table memory, registered read
`timescale 1ns / 1ps

module krta_table_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/krta_ctrl.sv @@
// scan sequencer, allocation and version bookkeeping
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krta_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  krta_pkg::krta_req_t    req_i,
  input  krta_pkg::krta_cfg_t    cfg_i,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output krta_pkg::krta_rsp_t    res_o,
  output krta_pkg::krta_ram_req_t ram_o,
  input  krta_pkg::krta_entry_t  ram_rdata_i
);
  import krta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  krta_req_t        req_q;
  logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [15:0]      hit_off_q, hit_off_d;
  logic [15:0]      hit_size_q, hit_size_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      free_start_q, free_start_d;
  logic [15:0]      free_bytes_q, free_bytes_d;
  logic [31:0]      version_q, version_d;
  logic [1:0]       part_q, part_d;

  logic             accept;
  logic             hit;
  logic             scan_end;
  logic             rd_en;
  logic [16:0]      aligned;
  logic [LIM_W-1:0] max_items_w;
  logic [LIM_W-1:0] limit;
  logic             room;
  logic             commit;
  logic             append;
  logic [2:0]       part_nxt;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // scan: one read issued per cycle, compare in the cycle after the read
  always_comb begin
    hit      = (state_q == S_SCAN) && pend_q && (ram_rdata_i.id == req_q.record_id);
    scan_end = (state_q == S_SCAN) && !hit && (scan_idx_q >= count_q);
    rd_en    = (state_q == S_SCAN) && !hit && (scan_idx_q < count_q);
  end

  // allocation check for a new id
  always_comb begin
    aligned     = ({1'b0, req_q.length} + ALIGN_MASK_X) & ~ALIGN_MASK_X;
    max_items_w = LIM_W'(cfg_i.max_items);
    limit       = (max_items_w > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : max_items_w;
    room        = (LIM_W'(count_q) < limit) && ({1'b0, free_bytes_q} >= aligned);
    commit      = (state_q == S_FINISH) && (req_q.mode == MODE_WRITE) && (found_q || room);
    append      = commit && !found_q;
    part_nxt    = {1'b0, part_q} + 3'd1;
    if ((part_nxt >= cfg_i.num_partitions) || (part_nxt > 3'd3)) begin
      part_nxt = 3'd0;
    end
  end

  always_comb begin
    state_d      = state_q;
    scan_idx_d   = scan_idx_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_off_d    = hit_off_q;
    hit_size_d   = hit_size_q;
    count_d      = count_q;
    free_start_d = free_start_q;
    free_bytes_d = free_bytes_q;
    version_d    = version_q;
    part_d       = part_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d    = S_SCAN;
          scan_idx_d = '0;
          found_d    = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          pend_d     = 1'b1;
          pend_idx_d = scan_idx_q[IDX_W-1:0];
          scan_idx_d = scan_idx_q + CNT_W'(1);
        end
        if (hit) begin
          found_d    = 1'b1;
          hit_idx_d  = pend_idx_q;
          hit_off_d  = ram_rdata_i.offset;
          hit_size_d = ram_rdata_i.size;
          state_d    = S_FINISH;
        end else if (scan_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
        if (commit) begin
          version_d = version_q + 32'd1;
          part_d    = part_nxt[1:0];
        end
        if (append) begin
          count_d      = count_q + CNT_W'(1);
          free_start_d = free_start_q + aligned[15:0];
          free_bytes_d = free_bytes_q - aligned[15:0];
        end
      end
      default: state_d = S_IDLE;
    endcase

    // the user must send a capacity write only while idle; the block itself does not enforce it
    if (cfg_i.cap_we) begin
      free_bytes_d = cfg_i.cap_value;
    end
  end

  // result formed in the finishing cycle
  always_comb begin
    res_o       = '0;
    res_valid_o = (state_q == S_FINISH);
    if (req_q.mode == MODE_READ) begin
      if (found_q) begin
        res_o.status        = ST_OK;
        res_o.byte_ofs      = hit_off_q;
        res_o.result_length = (req_q.length > hit_size_q) ? hit_size_q : req_q.length;
      end else begin
        res_o.status = ST_NOT_FOUND;
      end
    end else if (found_q || room) begin
      res_o.status          = ST_OK;
      res_o.byte_ofs        = found_q ? hit_off_q : free_start_q;
      res_o.result_length   = req_q.length;
      res_o.new_version     = version_q + 32'd1;
      res_o.store_partition = part_q;
      res_o.store_needed    = 1'b1;
    end else begin
      res_o.status = ST_NO_SPACE;
    end
  end

  always_comb begin
    ram_o.re           = rd_en;
    ram_o.raddr        = scan_idx_q[IDX_W-1:0];
    ram_o.we           = commit;
    ram_o.waddr        = found_q ? hit_idx_q : count_q[IDX_W-1:0];
    ram_o.wdata.id     = req_q.record_id;
    ram_o.wdata.offset = found_q ? hit_off_q : free_start_q;
    ram_o.wdata.size   = req_q.length;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      scan_idx_q   <= '0;
      count_q      <= '0;
      free_start_q <= '0;
      free_bytes_q <= CAPACITY_RST;
      version_q    <= VERSION_RST;
      part_q       <= '0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      scan_idx_q   <= scan_idx_d;
      count_q      <= count_d;
      free_start_q <= free_start_d;
      free_bytes_q <= free_bytes_d;
      version_q    <= version_d;
      part_q       <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_off_q  <= hit_off_d;
    hit_size_q <= hit_size_d;
  end

  `KRTA_ASSERT(a_count_in_depth, clk_i, rst_ni, (count_q <= CNT_W'(TABLE_DEPTH)), "entry count beyond table depth")
  `KRTA_ASSERT_NEXT(a_write_bumps_version, clk_i, rst_ni, ram_o.we, (version_q != $past(version_q)), "table write without version step")
  `KRTA_ASSERT_NEXT(a_accept_scans, clk_i, rst_ni, accept, (state_q == S_SCAN), "accepted beat did not start a scan")
  `KRTA_ASSERT_NEXT(a_result_then_idle, clk_i, rst_ni, res_valid_o, (state_q == S_IDLE && !pend_q), "sequencer not idle after result")

endmodule

@@ hdl/keyed_record_table_allocator.sv @@
// top level of the keyed record table allocator
`timescale 1ns / 1ps

// keyed record table allocator: a request beat (mode, record_id, length) is
// taken on a rising edge with start_i high and busy low. the table of
// records sits in one synchronous memory and is searched lowest index first,
// one entry read per cycle, with the compare in the cycle after the read. a
// request keeps busy high while it scans the entries below the record count
// (up to 128 with a full table) and the finishing step; a hit at index k
// ends the scan there, with no later reads. the result beat shows on
// rsp_o for exactly one cycle with done_o high, the cycle busy drops, so a
// new request may be issued in that same cycle. the receiver cannot stall:
// done_o is a strobe and the beat is gone after that cycle. configuration is
// a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) and must only be
// used while busy is low; writing the capacity register reloads the free
// byte count at once, leaving the free offset and the records alone. the
// memory needs no clearing pass after reset: only entries below the record
// count are ever read.
module keyed_record_table_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy,
  input  krta_pkg::krta_req_t req_i,
  output logic                done_o,
  output krta_pkg::krta_rsp_t rsp_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);
  import krta_pkg::*;

  // configuration registers
  logic [7:0]     max_items_q, max_items_d;
  logic [2:0]     num_part_q, num_part_d;
  krta_cfg_t      cfg;

  // controller to memory
  krta_ram_req_t  ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  krta_entry_t    ram_entry;

  // result register
  logic           res_valid;
  krta_rsp_t      res;
  logic           done_q;
  krta_rsp_t      rsp_q;

  always_comb begin
    max_items_d = max_items_q;
    num_part_d  = num_part_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_ITEMS: max_items_d = cfg_wdata_i[7:0];
        CFG_NUM_PART:  num_part_d  = cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_items_q <= MAX_ITEMS_RST;
      num_part_q  <= NUM_PART_RST;
    end else begin
      max_items_q <= max_items_d;
      num_part_q  <= num_part_d;
    end
  end

  // capacity write goes straight to the free byte counter
  always_comb begin
    cfg.max_items      = max_items_q;
    cfg.num_partitions = num_part_q;
    cfg.cap_we         = cfg_we_i && (cfg_idx_i == CFG_CAPACITY);
    cfg.cap_value      = cfg_wdata_i;
  end

  assign ram_entry = krta_entry_t'(ram_rdata);

  krta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_entry)
  );

  krta_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // result beat register, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      rsp_q <= res;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ verif/krta_table_checker.sv @@
// watcher that models the record table and checks every result beat of the allocator
`timescale 1ns / 1ps

module krta_table_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                busy_i,
  input  krta_pkg::krta_req_t req_i,
  input  logic                rsp_valid_i,
  input  krta_pkg::krta_rsp_t rsp_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  output int                  mismatch_count_o,
  output int                  answers_pending_o
);

  import krta_pkg::*;

  // model copy of the table and the allocator registers
  logic [15:0] rec_id     [TABLE_DEPTH];
  logic [15:0] rec_offset [TABLE_DEPTH];
  logic [15:0] rec_size   [TABLE_DEPTH];
  int unsigned rec_count;
  logic [15:0] free_ptr;
  logic [15:0] free_left;
  logic [31:0] version;
  logic [1:0]  part_next;
  logic [7:0]  item_cap;
  logic [2:0]  part_count;

  krta_rsp_t   table_answers_q[$];
  krta_rsp_t   oldest_answer;

  initial mismatch_count_o = 0;

  function automatic int find_record(logic [15:0] id);
    for (int i = 0; i < rec_count; i++) begin
      if (rec_id[i] == id) return i;
    end
    return -1;
  endfunction

  // applies one request to the model table and returns the answer it must produce
  function automatic krta_rsp_t serve_table_request(krta_req_t r);
    krta_rsp_t   ans;
    int          hit;
    int unsigned limit;
    logic [16:0] rounded;
    logic [2:0]  part_inc;
    ans = '0;
    hit = find_record(r.record_id);
    rounded = ({1'b0, r.length} + ALIGN_MASK_X) & ~ALIGN_MASK_X;
    limit = (item_cap > TABLE_DEPTH) ? TABLE_DEPTH : item_cap;
    if (r.mode == MODE_READ) begin
      if (hit >= 0) begin
        ans.status = ST_OK;
        ans.byte_ofs = rec_offset[hit];
        ans.result_length = (r.length > rec_size[hit]) ? rec_size[hit] : r.length;
      end else begin
        ans.status = ST_NOT_FOUND;
      end
      return ans;
    end
    if (hit >= 0) begin
      // update keeps the slot, no fit check
      rec_size[hit] = r.length;
      ans.byte_ofs = rec_offset[hit];
      ans.result_length = r.length;
    end else if (rec_count < limit && {1'b0, free_left} >= rounded) begin
      rec_id[rec_count] = r.record_id;
      rec_offset[rec_count] = free_ptr;
      rec_size[rec_count] = r.length;
      ans.byte_ofs = free_ptr;
      ans.result_length = r.length;
      free_ptr = free_ptr + rounded[15:0];
      free_left = free_left - rounded[15:0];
      rec_count++;
    end else begin
      ans.status = ST_NO_SPACE;
      return ans;
    end
    ans.status = ST_OK;
    version = version + 32'd1;
    ans.new_version = version;
    ans.store_partition = part_next;
    ans.store_needed = 1'b1;
    part_inc = {1'b0, part_next} + 3'd1;
    part_next = (part_inc >= part_count || part_inc > 3'd3) ? 2'd0 : part_inc[1:0];
    return ans;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_count = 0;
      free_ptr = '0;
      free_left = CAPACITY_RST;
      version = VERSION_RST;
      part_next = '0;
      item_cap = MAX_ITEMS_RST;
      part_count = NUM_PART_RST;
      table_answers_q.delete();
      answers_pending_o <= 0;
    end else begin
      // the result leaving now belongs to an earlier request, so pop before push
      if (rsp_valid_i) begin
        if (table_answers_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time, rsp_i);
        end else begin
          oldest_answer = table_answers_q.pop_front();
          check_field("status", 32'(oldest_answer.status), 32'(rsp_i.status));
          check_field("byte_ofs", 32'(oldest_answer.byte_ofs), 32'(rsp_i.byte_ofs));
          check_field("result_length", 32'(oldest_answer.result_length),
                      32'(rsp_i.result_length));
          check_field("new_version", oldest_answer.new_version, rsp_i.new_version);
          check_field("store_partition", 32'(oldest_answer.store_partition),
                      32'(rsp_i.store_partition));
          check_field("store_needed", 32'(oldest_answer.store_needed),
                      32'(rsp_i.store_needed));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_ITEMS: item_cap = cfg_wdata_i[7:0];
          CFG_NUM_PART:  part_count = cfg_wdata_i[2:0];
          CFG_CAPACITY:  free_left = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_valid_i && !busy_i) begin
        table_answers_q.push_back(serve_table_request(req_i));
      end
      answers_pending_o <= table_answers_q.size();
    end
  end

endmodule

@@ verif/tb_keyed_record_table_allocator.sv @@
// testbench top of the keyed record table allocator: stimulus, config phases and verdict
`timescale 1ns / 1ps

module tb_keyed_record_table_allocator;

  import krta_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 8;
  // limit sized well above the slowest request and the long sender gaps
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 650;
  localparam int NUM_PHASES    = 8;
  localparam int ID_POOL_SIZE  = 160;
  localparam int SETTLE_CYCLES = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy;
  krta_req_t   req_i;
  logic        done_o;
  krta_rsp_t   rsp_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  int          mismatches;
  int          answers_pending;
  int          cycle_count = 0;

  // ids that the random part keeps coming back to, so reads hit and updates happen
  logic [15:0] id_pool [ID_POOL_SIZE];

  keyed_record_table_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  krta_table_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (start_i),
    .busy_i            (busy),
    .req_i             (req_i),
    .rsp_valid_i       (done_o),
    .rsp_i             (rsp_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mismatch_count_o  (mismatches),
    .answers_pending_o (answers_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog, a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request beat: start stays high until an edge sees busy low,
  // and is left high so a following beat can go out back to back
  task automatic send_request(krta_mode_e mode, logic [15:0] id, logic [15:0] len);
    start_i <= 1'b1;
    req_i <= '{mode: mode, record_id: id, length: len};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // random sender gap after an accepted beat, mostly none or short, a few long
  task automatic idle_sender(int gap_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= gap_pct) return;
    start_i <= 1'b0;
    if ($urandom_range(0, 9) < 8) begin
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end else begin
      repeat ($urandom_range(8, 60)) @(posedge clk_i);
    end
  endtask

  // hold off until every predicted answer has come back and the block is idle
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (answers_pending != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all three registers back to back, only ever called while idle;
  // unused upper data bits carry noise, the block keeps only the low bits
  task automatic write_settings(logic [7:0] items, logic [2:0] parts, logic [15:0] capacity);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MAX_ITEMS;
    cfg_wdata_i <= {8'($urandom), items};
    @(posedge clk_i);
    cfg_idx_i <= CFG_NUM_PART;
    cfg_wdata_i <= {13'($urandom), parts};
    @(posedge clk_i);
    cfg_idx_i <= CFG_CAPACITY;
    cfg_wdata_i <= capacity;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_item(int read_pct, int gap_pct);
    krta_mode_e  mode;
    logic [15:0] id;
    logic [15:0] len;
    int          pick;
    mode = ($urandom_range(0, 99) < read_pct) ? MODE_READ : MODE_WRITE;
    // mostly pool ids, some fully random ones that usually miss
    id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]
                                    : 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = 16'($urandom_range(0, 300));
    end else if (pick < 80) begin
      len = 16'($urandom);
    end else if (pick < 94) begin
      // just below, on and just above an alignment step
      len = 16'($urandom_range(1, 40) * 64 + $urandom_range(0, 2) - 1);
    end else begin
      len = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    send_request(mode, id, len);
    idle_sender(gap_pct);
  endtask

  initial begin
    int read_pct;
    int gap_pct;
    int per_phase;

    rst_ni <= 1'b0;
    start_i <= 1'b0;
    req_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_MAX_ITEMS;
    cfg_wdata_i <= '0;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on reset settings: free space starts at 64756
    send_request(MODE_READ, 16'h0000, 16'hFFFF);    // empty table, not found
    send_request(MODE_WRITE, 16'h0000, 16'h0000);   // zero length takes no space
    send_request(MODE_WRITE, 16'hFFFF, 16'h0001);   // rounds up to one 64 byte step
    idle_sender(100);
    send_request(MODE_WRITE, 16'h1234, 16'hFFFF);   // rounds past 16 bits, no space
    send_request(MODE_WRITE, 16'hAAAA, 16'h0040);   // exact step, no round up
    send_request(MODE_WRITE, 16'h5555, 16'hFFC1);   // smallest length rounding past 16 bits
    send_request(MODE_READ, 16'hFFFF, 16'hFFFF);    // clipped to the stored size
    send_request(MODE_READ, 16'hFFFF, 16'h0000);
    send_request(MODE_WRITE, 16'hFFFF, 16'd200);    // update grows past its old slot
    send_request(MODE_READ, 16'hFFFF, 16'hFFFF);
    send_request(MODE_READ, 16'hAAAA, 16'h5555);
    send_request(MODE_READ, 16'h0000, 16'h0005);
    send_request(MODE_WRITE, 16'h0101, 16'd64576);  // leaves 52 bytes free
    send_request(MODE_WRITE, 16'h0202, 16'd52);     // rounds to 64, one step short
    send_request(MODE_WRITE, 16'h0202, 16'h0000);   // still fits with zero length
    send_request(MODE_READ, 16'h0202, 16'h0009);

    // capacity at its top, next create pushes the free offset past 16 bits
    drain_results();
    write_settings(8'd126, 3'd4, 16'hFFFF);
    send_request(MODE_WRITE, 16'h0303, 16'd1000);
    send_request(MODE_WRITE, 16'h0404, 16'hFFC0);   // exact step but larger than free
    send_request(MODE_WRITE, 16'h0404, 16'd63);     // lands on the wrapped offset
    send_request(MODE_READ, 16'h0303, 16'd2000);
    send_request(MODE_READ, 16'h7FFF, 16'h0001);

    // item limit equal to the record count, single partition
    drain_results();
    write_settings(8'd7, 3'd1, 16'hFFFF);
    send_request(MODE_WRITE, 16'h0505, 16'd10);     // count at the limit, refused
    send_request(MODE_WRITE, 16'h0404, 16'd10);     // updates still succeed
    send_request(MODE_WRITE, 16'h0101, 16'h0000);
    drain_results();

    // random phases, each with its own settings, read share and gap density
    per_phase = RANDOM_ITEMS / NUM_PHASES;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin  // limit above table depth saturates, count 7 acts as 4
          write_settings(8'd255, 3'd7, 16'hFFFF);
          read_pct = 30;
          gap_pct = 35;
        end
        1: begin  // zero limit refuses every create, zero partitions stay at 0
          write_settings(8'd0, 3'd0, 16'h0000);
          read_pct = 50;
          gap_pct = 35;
        end
        2: begin  // odd partition count
          write_settings(8'd128, 3'd3, 16'd20000);
          read_pct = 35;
          gap_pct = 0;
        end
        3: begin
          write_settings(8'd1, 3'd1, 16'd100);
          read_pct = 45;
          gap_pct = 50;
        end
        4: begin
          write_settings(8'd200, 3'd2, 16'hFFFF);
          read_pct = 30;
          gap_pct = 20;
        end
        5: begin  // count 5 acts as 4
          write_settings(8'd126, 3'd5, 16'd4000);
          read_pct = 40;
          gap_pct = 35;
        end
        6: begin
          write_settings(8'd129, 3'd6, 16'hFFFF);
          read_pct = 30;
          gap_pct = 35;
        end
        default: begin
          write_settings(8'd64, 3'd4, 16'd64756);
          read_pct = 55;
          gap_pct = 35;
        end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        send_random_item(read_pct, gap_pct);
        // now and then let the pipe run dry mid phase
        if ($urandom_range(0, 99) < 2) drain_results();
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/krta_pkg.sv
hdl/krta_table_ram.sv
hdl/krta_ctrl.sv
hdl/keyed_record_table_allocator.sv
verif/krta_table_checker.sv
verif/tb_keyed_record_table_allocator.sv
